// ----- rtl/core/spe_pkg.sv -----
package spe_pkg;

    localparam int NDIM       = 2;
    localparam int MAX_SUBDIV = 16;
    localparam int NF         = 2;
    localparam int NW_MAX     = 1024;

    localparam int NBP    = MAX_SUBDIV + 1;
    localparam int C_W    = $clog2(NBP);
    localparam int DW     = (NDIM > 1) ? $clog2(NDIM) : 1;
    localparam int JW     = $clog2(NDIM + 1);
    localparam int KW     = (NF > 1) ? $clog2(NF) : 1;
    localparam int FRAC_W = 16;
    localparam int IT_W   = $clog2(FRAC_W);
    localparam int MU_W   = FRAC_W + 1;
    localparam int VA_W   = $clog2((MAX_SUBDIV + 2) ** NDIM) + 1;
    localparam int WAW    = $clog2(NW_MAX);
    localparam int WMA_W  = $clog2(NF * NW_MAX);
    localparam int BPA_W  = $clog2(NDIM * NBP);
    localparam int PROD_W = MU_W + 1 + 32;
    localparam int ACC_W  = PROD_W + JW;

    localparam int CFG_N  = 4;
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 5;

    typedef enum logic [1:0] {
        CMD_WR_BP  = 2'd0,
        CMD_WR_W   = 2'd1,
        CMD_WR_BND = 2'd2,
        CMD_EVAL   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DSTART, S_SCAN, S_SEND, S_DINIT, S_DIV, S_DDONE,
        S_SORT, S_ADDR, S_RD, S_MUL, S_ACC, S_OLOAD, S_OWAIT
    } t_state;

    typedef struct packed {
        t_cmd               cmd;
        logic [2:0]         lane_sel;
        logic [9:0]         entry_index;
        logic signed [31:0] write_value;
        logic signed [31:0] coord_0;
        logic signed [31:0] coord_1;
        logic signed [31:0] coord_2;
        logic signed [31:0] coord_3;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         out_index;
        logic signed [31:0] out_value;
        logic               outside;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic            scan_clr;
        logic            bp_rd;
        logic [C_W-1:0]  bp_ix;
        logic [DW-1:0]   d;
        logic            div_init;
        logic            div_step;
        logic            dim_done;
        logic            sort;
        logic            addr_calc;
        logic [JW-1:0]   j;
        logic            w_rd;
        logic [KW-1:0]   k;
        logic            mul;
        logic            acc;
        logic            out_load;
        logic            out_valid;
    } t_ctl;

    typedef struct packed {
        logic           outside;
        logic           match;
        logic           eq;
        logic [C_W-1:0] ncell;
    } t_stat;

    function automatic logic [C_W-1:0] cells_of(input logic [CFG_DW-1:0] v);
        logic [C_W-1:0] r;
        if (v < 1) begin
            r = C_W'(1);
        end else if (int'(v) > MAX_SUBDIV) begin
            r = C_W'(MAX_SUBDIV);
        end else begin
            r = C_W'(v);
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/spe_ctrl.sv -----
module spe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_acc_eval,
    input  spe_pkg::t_stat i_stat,
    input  logic           i_out_ready,
    output spe_pkg::t_ctl  o_ctl,
    output logic           o_in_ready
);
    import spe_pkg::*;

    t_state          r_state, n_state;
    logic [DW-1:0]   r_d, n_d;
    logic [C_W-1:0]  r_c, n_c;
    logic [IT_W-1:0] r_it, n_it;
    logic [JW-1:0]   r_j, n_j;
    logic [KW-1:0]   r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_d     <= '0;
            r_c     <= '0;
            r_it    <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_d     <= n_d;
            r_c     <= n_c;
            r_it    <= n_it;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_d     = r_d;
        n_c     = r_c;
        n_it    = r_it;
        n_j     = r_j;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_acc_eval) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_k = '0;
                n_j = '0;
                n_d = '0;
                n_state = i_stat.outside ? S_OLOAD : S_DSTART;
            end
            S_DSTART: begin
                n_c = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_c == i_stat.ncell) begin
                    n_state = S_SEND;
                end else begin
                    n_c = r_c + 1'b1;
                end
            end
            S_SEND: n_state = S_DINIT;
            S_DINIT: begin
                n_it = '0;
                n_state = (i_stat.eq || !i_stat.match) ? S_DDONE : S_DIV;
            end
            S_DIV: begin
                n_it = r_it + 1'b1;
                if (r_it == IT_W'(FRAC_W - 1)) begin
                    n_state = S_DDONE;
                end
            end
            S_DDONE: begin
                if (r_d == DW'(NDIM - 1)) begin
                    n_state = S_SORT;
                end else begin
                    n_d = r_d + 1'b1;
                    n_state = S_DSTART;
                end
            end
            S_SORT: begin
                n_j = '0;
                n_k = '0;
                n_state = S_ADDR;
            end
            S_ADDR: n_state = S_RD;
            S_RD:   n_state = S_MUL;
            S_MUL:  n_state = S_ACC;
            S_ACC: begin
                if (r_j == JW'(NDIM)) begin
                    n_state = S_OLOAD;
                end else begin
                    n_j = r_j + 1'b1;
                    n_state = S_ADDR;
                end
            end
            S_OLOAD: n_state = S_OWAIT;
            S_OWAIT: begin
                if (i_out_ready) begin
                    if (r_k == KW'(NF - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + 1'b1;
                        n_j = '0;
                        n_state = i_stat.outside ? S_OLOAD : S_ADDR;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl       = '0;
        o_ctl.d     = r_d;
        o_ctl.bp_ix = r_c;
        o_ctl.j     = r_j;
        o_ctl.k     = r_k;
        unique case (r_state)
            S_DSTART: o_ctl.scan_clr  = 1'b1;
            S_SCAN:   o_ctl.bp_rd     = 1'b1;
            S_DINIT:  o_ctl.div_init  = 1'b1;
            S_DIV:    o_ctl.div_step  = 1'b1;
            S_DDONE:  o_ctl.dim_done  = 1'b1;
            S_SORT:   o_ctl.sort      = 1'b1;
            S_ADDR:   o_ctl.addr_calc = 1'b1;
            S_RD:     o_ctl.w_rd      = 1'b1;
            S_MUL:    o_ctl.mul       = 1'b1;
            S_ACC:    o_ctl.acc       = 1'b1;
            S_OLOAD:  o_ctl.out_load  = 1'b1;
            S_OWAIT:  o_ctl.out_valid = 1'b1;
            default: ;
        endcase
        o_in_ready = (r_state == S_IDLE);
    end

endmodule

// ----- rtl/core/spe_datapath.sv -----
module spe_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_acc,
    input  spe_pkg::t_in_item         i_in,
    input  logic                      i_cfg_we,
    input  logic [spe_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [spe_pkg::CFG_DW-1:0] i_cfg_data,
    input  spe_pkg::t_ctl             i_ctl,
    output spe_pkg::t_stat            o_stat,
    output spe_pkg::t_out_item        o_out
);
    import spe_pkg::*;

    logic signed [31:0] r_bp_mem [NDIM*NBP];
    logic signed [31:0] r_w_mem  [NF*NW_MAX];
    logic signed [31:0] r_bnd    [NDIM][2];
    logic [CFG_DW-1:0]  r_subdiv [CFG_N];

    logic signed [31:0] r_x [NDIM];
    logic               r_outside;
    logic [C_W-1:0]     r_cell [NDIM];
    logic [FRAC_W-1:0]  r_fr   [NDIM];
    logic [FRAC_W-1:0]  r_s    [NDIM];
    logic [FRAC_W-1:0]  n_s    [NDIM];

    logic               r_bp_vld;
    logic [C_W-1:0]     r_bp_ix;
    logic signed [31:0] r_bp_q, r_prev, r_lo, r_hi;
    logic               r_match, r_eq;
    logic [C_W-1:0]     r_mcell;
    logic [32:0]        r_rem, r_dv;
    logic [FRAC_W-1:0]  r_quo;

    logic [VA_W-1:0]    r_addr;
    logic               r_addr_ok;
    logic [MU_W-1:0]    r_mu;
    logic signed [31:0] r_w;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    t_out_item          r_out;

    logic signed [31:0] x_in [4];
    logic               out_flag;
    logic signed [31:0] x_cur;
    logic [C_W-1:0]     ncell;
    logic signed [32:0] diff_lo, diff_w;
    logic [33:0]        rem2;
    logic [VA_W-1:0]    addr_c;
    logic [MU_W-1:0]    mu_c;
    logic [DW-1:0]      jm1, jx;
    logic signed [ACC_W-1:0] half_q, sat_hi, sat_lo, rnd;
    logic signed [31:0] val_c;
    logic               is_wr;

    assign x_in[0] = i_in.coord_0;
    assign x_in[1] = i_in.coord_1;
    assign x_in[2] = i_in.coord_2;
    assign x_in[3] = i_in.coord_3;
    assign is_wr   = i_acc && (i_in.cmd != CMD_EVAL);

    always_comb begin
        out_flag = 1'b0;
        for (int d = 0; d < NDIM; d++) begin
            if (x_in[d] < r_bnd[d][0] || x_in[d] > r_bnd[d][1]) begin
                out_flag = 1'b1;
            end
        end
    end

    assign x_cur   = r_x[i_ctl.d];
    assign ncell   = cells_of(r_subdiv[CFG_AW'(i_ctl.d)]);
    assign diff_lo = 33'(x_cur) - 33'(r_lo);
    assign diff_w  = 33'(r_hi) - 33'(r_lo);
    assign rem2    = {r_rem, 1'b0};

    // config and store writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_N; i++) begin
                r_subdiv[i] <= CFG_DW'(1);
            end
        end else if (i_cfg_we) begin
            r_subdiv[i_cfg_addr] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_wr && i_in.cmd == CMD_WR_BP && int'(i_in.lane_sel) < NDIM
            && int'(i_in.entry_index) <= MAX_SUBDIV) begin
            r_bp_mem[BPA_W'(int'(i_in.lane_sel) * NBP + int'(i_in.entry_index))]
                <= i_in.write_value;
        end
        if (i_ctl.bp_rd) begin
            r_bp_q <= r_bp_mem[BPA_W'(int'(i_ctl.d) * NBP + int'(i_ctl.bp_ix))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_wr && i_in.cmd == CMD_WR_W && int'(i_in.lane_sel) < NF
            && int'(i_in.entry_index) < NW_MAX) begin
            r_w_mem[WMA_W'(int'(i_in.lane_sel) * NW_MAX + int'(i_in.entry_index))]
                <= i_in.write_value;
        end
        if (i_ctl.w_rd) begin
            r_w <= r_w_mem[WMA_W'(int'(i_ctl.k) * NW_MAX + int'(r_addr[WAW-1:0]))];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int d = 0; d < NDIM; d++) begin
            if (is_wr && i_in.cmd == CMD_WR_BND && int'(i_in.lane_sel) == d
                && i_in.entry_index <= 10'd1) begin
                r_bnd[d][i_in.entry_index[0]] <= i_in.write_value;
            end
        end
    end

    // point capture
    always_ff @(posedge i_clk) begin
        if (i_acc && i_in.cmd == CMD_EVAL) begin
            for (int d = 0; d < NDIM; d++) begin
                r_x[d] <= x_in[d];
            end
            r_outside <= out_flag;
        end
    end

    // breakpoint scan, one breakpoint a beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp_vld <= 1'b0;
            r_match  <= 1'b0;
            r_eq     <= 1'b0;
        end else begin
            r_bp_vld <= i_ctl.bp_rd;
            if (i_ctl.scan_clr) begin
                r_match <= 1'b0;
                r_eq    <= 1'b0;
            end else if (r_bp_vld) begin
                if (r_bp_ix != '0 && x_cur >= r_prev && x_cur < r_bp_q) begin
                    r_match <= 1'b1;
                end
                if (r_bp_ix == ncell && x_cur == r_bp_q) begin
                    r_eq <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bp_ix <= i_ctl.bp_ix;
        if (r_bp_vld) begin
            r_prev <= r_bp_q;
            if (r_bp_ix != '0 && x_cur >= r_prev && x_cur < r_bp_q) begin
                r_mcell <= r_bp_ix - 1'b1;
                r_lo    <= r_prev;
                r_hi    <= r_bp_q;
            end
        end
    end

    // restoring division, one quotient bit a beat
    always_ff @(posedge i_clk) begin
        if (i_ctl.div_init) begin
            r_rem <= 33'(diff_lo);
            r_dv  <= 33'(diff_w);
            r_quo <= '0;
        end else if (i_ctl.div_step) begin
            if (rem2 >= {1'b0, r_dv}) begin
                r_rem <= 33'(rem2 - {1'b0, r_dv});
                r_quo <= {r_quo[FRAC_W-2:0], 1'b1};
            end else begin
                r_rem <= rem2[32:0];
                r_quo <= {r_quo[FRAC_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.dim_done) begin
            r_cell[i_ctl.d] <= r_eq ? ncell : (r_match ? r_mcell : '0);
            r_fr[i_ctl.d]   <= (r_eq || !r_match) ? '0 : r_quo;
        end
    end

    // descending order, ties kept in dimension order
    always_comb begin
        int rank;
        for (int d = 0; d < NDIM; d++) begin
            n_s[d] = r_s[d];
        end
        for (int d = 0; d < NDIM; d++) begin
            rank = 0;
            for (int e = 0; e < NDIM; e++) begin
                if (r_fr[e] > r_fr[d] || (r_fr[e] == r_fr[d] && e < d)) begin
                    rank = rank + 1;
                end
            end
            n_s[DW'(rank)] = r_fr[d];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sort) begin
            for (int d = 0; d < NDIM; d++) begin
                r_s[d] <= n_s[d];
            end
        end
    end

    assign jm1 = DW'(i_ctl.j - 1'b1);
    assign jx  = DW'(i_ctl.j);

    // mixed-radix vertex address and barycentric coefficient
    always_comb begin
        logic [VA_W-1:0] coeff, v;
        addr_c = '0;
        coeff  = VA_W'(1);
        for (int d = 0; d < NDIM; d++) begin
            v = VA_W'(r_cell[d]);
            if (i_ctl.j != '0 && r_fr[d] >= r_s[jm1]) begin
                v = v + 1'b1;
            end
            addr_c = addr_c + VA_W'(coeff * v);
            coeff  = VA_W'(coeff * (VA_W'(cells_of(r_subdiv[d])) + 1'b1));
        end
        if (i_ctl.j == '0) begin
            mu_c = MU_W'(1 << FRAC_W) - MU_W'(r_s[0]);
        end else if (i_ctl.j == JW'(NDIM)) begin
            mu_c = MU_W'(r_s[jm1]);
        end else begin
            mu_c = MU_W'(r_s[jm1]) - MU_W'(r_s[jx]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.addr_calc) begin
            r_addr    <= addr_c;
            r_addr_ok <= (int'(addr_c) < NW_MAX);
            r_mu      <= mu_c;
        end
        if (i_ctl.mul) begin
            if (r_addr_ok && r_mu != '0) begin
                r_prod <= $signed({1'b0, r_mu}) * r_w;
            end else begin
                r_prod <= '0;
            end
        end
        if (i_ctl.acc) begin
            r_acc <= (i_ctl.j == '0) ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
    end

    // round half up, then saturate
    assign half_q = ACC_W'(1) << (FRAC_W - 1);
    assign sat_hi = ACC_W'(32'h7FFF_FFFF);
    assign sat_lo = -sat_hi - 1'b1;
    assign rnd    = (r_acc + half_q) >>> FRAC_W;

    always_comb begin
        if (rnd > sat_hi) begin
            val_c = 32'sh7FFF_FFFF;
        end else if (rnd < sat_lo) begin
            val_c = -32'sh7FFF_FFFF - 1'b1;
        end else begin
            val_c = rnd[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out.out_index <= 3'(i_ctl.k);
            r_out.out_value <= r_outside ? 32'sh7FFF_FFFF : val_c;
            r_out.outside   <= r_outside;
            r_out.last      <= (i_ctl.k == KW'(NF - 1));
        end
    end

    assign o_stat.outside = r_outside;
    assign o_stat.match   = r_match;
    assign o_stat.eq      = r_eq;
    assign o_stat.ncell   = ncell;
    assign o_out          = r_out;

endmodule

// ----- rtl/core/simplicial_pwa_evaluator_core.sv -----
// Piecewise-affine evaluator on a simplicial split of a non-uniform grid. Write beats
// (breakpoint, weight, bound) give no result and leave the block ready for the next
// beat. An evaluate beat gives NF results in output order, the final one marked last;
// a point outside the bounds gives results flagged outside with the saturated value.
// The time a point takes is set by the one-breakpoint-per-cycle scan, the 16-step
// serial divider per dimension and one weight-memory read and multiply-accumulate
// per simplex vertex; a dimension with no matching cell, or with the point on its
// top breakpoint, skips its divider steps. An outside point skips the scan, the
// divider and the multiply-accumulate. Each stalled result beat adds its stall. A new
// beat is taken only once every result of the previous point has been delivered.
// Stores are not cleared at reset and must be written before use.
module simplicial_pwa_evaluator_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  spe_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output spe_pkg::t_out_item         o_out_data,
    input  logic                       i_cfg_we,
    input  logic [spe_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [spe_pkg::CFG_DW-1:0] i_cfg_data
);
    import spe_pkg::*;

    t_ctl  ctl;
    t_stat stat;
    logic  in_acc;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = ctl.out_valid;

    spe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc_eval  (in_acc && i_in_data.cmd == CMD_EVAL),
        .i_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_ctl       (ctl),
        .o_in_ready  (o_in_ready)
    );

    spe_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (in_acc),
        .i_in       (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (ctl),
        .o_stat     (stat),
        .o_out      (o_out_data)
    );

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a result beat is pending");

    a_free_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.last |=> o_in_ready)
        else $error("block not free after last result beat");

    a_outside_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.outside |-> o_out_data.out_value == 32'sh7FFF_FFFF)
        else $error("outside result without saturated value");

endmodule

// ----- test/simplicial_pwa_evaluator_core_tb.sv -----
`timescale 1ns / 1ps

module simplicial_pwa_evaluator_core_tb;
    import spe_pkg::*;

    localparam int  MDL       = 0;   // state as seen by the checker
    localparam int  GEN       = 1;   // state as seen by the stimulus builder
    localparam int  CYC_LIMIT = 600000;
    localparam int  DRAIN_CYC = 200;
    localparam int  IN_W      = $bits(t_in_item);

    localparam int  GRID_UNIFORM   = 0;
    localparam int  GRID_IRREGULAR = 1;
    localparam int  GRID_WIDE      = 2;
    localparam int  GRID_UNSORTED  = 3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              in_data = '0;
    logic                  o_out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_AW-1:0]     cfg_addr = '0;
    logic [CFG_DW-1:0]     cfg_data = '0;

    logic signed [31:0]    bp_st  [2][NDIM][NBP];
    logic signed [31:0]    bnd_st [2][NDIM][2];
    logic signed [31:0]    wt_st  [2][NF][NW_MAX];
    logic [CFG_DW-1:0]     subdiv [2][CFG_N];
    bit                    w_written [NF][NW_MAX];
    int                    vx_addr [2][NDIM+1];
    longint                vx_mu   [2][NDIM+1];

    t_in_item              pend_q[$];
    t_out_item             exp_q[$];
    int                    fails = 0;
    int                    cyc = 0;
    bit                    quiet;
    int                    grid_mode;

    simplicial_pwa_evaluator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    assign quiet = (cyc >= 4000) && (cyc < 12000);

    function automatic int n_cells(int v, int d);
        int n;
        n = int'(subdiv[v][d]);
        if (n < 1) n = 1;
        if (n > MAX_SUBDIV) n = MAX_SUBDIV;
        return n;
    endfunction

    function automatic longint coord_of(t_in_item it, int d);
        case (d)
            0: return longint'(it.coord_0);
            1: return longint'(it.coord_1);
            2: return longint'(it.coord_2);
            default: return longint'(it.coord_3);
        endcase
    endfunction

    function automatic void store_beat(int v, t_in_item it);
        int lane;
        int ix;
        lane = int'(it.lane_sel);
        ix   = int'(it.entry_index);
        case (it.cmd)
            CMD_WR_BP: begin
                if (lane < NDIM && ix <= MAX_SUBDIV) bp_st[v][lane][ix] = it.write_value;
            end
            CMD_WR_W: begin
                if (lane < NF && ix < NW_MAX) begin
                    wt_st[v][lane][ix] = it.write_value;
                    if (v == GEN) w_written[lane][ix] = 1'b1;
                end
            end
            CMD_WR_BND: begin
                if (lane < NDIM && ix <= 1) bnd_st[v][lane][ix] = it.write_value;
            end
            default: ;
        endcase
    endfunction

    // returns 1 when the point is off the domain, else fills the simplex vertices
    function automatic bit locate_simplex(int v, t_in_item it);
        longint x, lo, hi, t;
        longint fr [NDIM];
        longint s  [NDIM];
        int     cix [NDIM];
        int     n, i, a, coef, vv;
        for (int d = 0; d < NDIM; d++) begin
            x = coord_of(it, d);
            if (x < longint'(bnd_st[v][d][0]) || x > longint'(bnd_st[v][d][1])) return 1'b1;
        end
        for (int d = 0; d < NDIM; d++) begin
            x = coord_of(it, d);
            n = n_cells(v, d);
            cix[d] = 0;
            fr[d] = 0;
            for (int c = 0; c < n; c++) begin
                lo = longint'(bp_st[v][d][c]);
                hi = longint'(bp_st[v][d][c+1]);
                if (x >= lo && x < hi) begin
                    cix[d] = c;
                    fr[d] = ((x - lo) <<< 16) / (hi - lo);
                end
            end
            if (x == longint'(bp_st[v][d][n])) begin
                cix[d] = n;
                fr[d] = 0;
            end
        end
        for (int d = 0; d < NDIM; d++) s[d] = fr[d];
        for (int d = 1; d < NDIM; d++) begin
            t = s[d];
            i = d - 1;
            while (i >= 0 && s[i] < t) begin
                s[i+1] = s[i];
                i--;
            end
            s[i+1] = t;
        end
        for (int j = 0; j <= NDIM; j++) begin
            a = 0;
            coef = 1;
            for (int d = 0; d < NDIM; d++) begin
                vv = cix[d];
                // a tie with the sorted fraction counts as a step taken
                if (j > 0 && fr[d] >= s[j-1]) vv = vv + 1;
                a = a + coef * vv;
                coef = coef * (n_cells(v, d) + 1);
            end
            vx_addr[v][j] = a;
        end
        vx_mu[v][0] = 65536 - s[0];
        for (int j = 1; j < NDIM; j++) vx_mu[v][j] = s[j-1] - s[j];
        vx_mu[v][NDIM] = s[NDIM-1];
        return 1'b0;
    endfunction

    function automatic void predict_point(t_in_item it);
        bit        off_grid;
        longint    acc, r;
        t_out_item res;
        off_grid = locate_simplex(MDL, it);
        for (int k = 0; k < NF; k++) begin
            res = '0;
            res.out_index = 3'(k);
            res.last = (k == NF - 1);
            if (off_grid) begin
                res.out_value = 32'sh7FFFFFFF;
                res.outside = 1'b1;
            end else begin
                acc = 0;
                for (int j = 0; j <= NDIM; j++) begin
                    if (vx_mu[MDL][j] != 0 && vx_addr[MDL][j] < NW_MAX)
                        acc += vx_mu[MDL][j] * longint'(wt_st[MDL][k][vx_addr[MDL][j]]);
                end
                r = (acc + 32768) >>> 16;
                if (r > 64'sd2147483647) r = 64'sd2147483647;
                if (r < -64'sd2147483648) r = -64'sd2147483648;
                res.out_value = 32'(r);
            end
            exp_q.push_back(res);
        end
    endfunction

    function automatic longint rnd_range(longint lo, longint hi);
        logic [62:0] r;
        if (hi <= lo) return lo;
        r = 63'({$urandom, $urandom});
        return lo + longint'(r % 63'(hi - lo + 1));
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [31:0] rand_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 32'h7FFFFFFF;
        if (r < 10) return 32'h80000000;
        if (r < 25) return $urandom;
        return 32'($urandom_range(0, 400000)) - 32'd200000;
    endfunction

    function automatic t_in_item noise_item();
        t_in_item it;
        it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        return it;
    endfunction

    task automatic add_write(t_cmd c, int lane, int ix, logic [31:0] val);
        t_in_item it;
        it = noise_item();
        it.cmd = c;
        it.lane_sel = 3'(lane);
        it.entry_index = 10'(ix);
        it.write_value = val;
        store_beat(GEN, it);
        pend_q.push_back(it);
    endtask

    // every weight the point will use gets written first
    task automatic add_point(longint c0, longint c1);
        t_in_item it;
        int       a;
        it = noise_item();
        it.cmd = CMD_EVAL;
        it.coord_0 = 32'(clip32(c0));
        it.coord_1 = 32'(clip32(c1));
        if (!locate_simplex(GEN, it)) begin
            for (int j = 0; j <= NDIM; j++) begin
                a = vx_addr[GEN][j];
                if (vx_mu[GEN][j] != 0 && a < NW_MAX) begin
                    for (int k = 0; k < NF; k++)
                        if (!w_written[k][a]) add_write(CMD_WR_W, k, a, rand_weight());
                end
            end
        end
        pend_q.push_back(it);
    endtask

    task automatic set_config(int v0, int v1, int v2, int v3);
        int vals [CFG_N];
        vals = '{v0, v1, v2, v3};
        for (int r = 0; r < CFG_N; r++) begin
            @(posedge i_clk);
            cfg_we   <= 1'b1;
            cfg_addr <= CFG_AW'(r);
            cfg_data <= CFG_DW'(vals[r]);
            subdiv[GEN][r] = CFG_DW'(vals[r]);
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup_grid(int mode);
        longint base, step, val, margin;
        grid_mode = mode;
        for (int d = 0; d < NDIM; d++) begin
            base = rnd_range(-(64'sd1 <<< 22), 64'sd1 <<< 22);
            step = rnd_range(1, 64'sd1 <<< 18);
            val = base;
            for (int i = 0; i < NBP; i++) begin
                case (mode)
                    GRID_UNIFORM:   val = base + i * step;
                    GRID_IRREGULAR: if (i > 0) val = val + (($urandom_range(0, 5) == 0) ?
                                        1 : rnd_range(1, 64'sd1 <<< 20));
                    GRID_WIDE:      val = -64'sd2147483648 + i * 64'sd268435455;
                    default:        val = rnd_range(-(64'sd1 <<< 20), 64'sd1 <<< 20);
                endcase
                add_write(CMD_WR_BP, d, i, 32'(val));
            end
            margin = (mode == GRID_WIDE) ? 0 : rnd_range(0, 64'sd1 <<< 16);
            if (mode == GRID_UNSORTED) begin
                add_write(CMD_WR_BND, d, 0, 32'(-(64'sd1 <<< 20)));
                add_write(CMD_WR_BND, d, 1, 32'(64'sd1 <<< 20));
            end else begin
                add_write(CMD_WR_BND, d, 0, 32'(clip32(longint'(bp_st[GEN][d][0]) - margin)));
                add_write(CMD_WR_BND, d, 1,
                          32'(clip32(longint'(bp_st[GEN][d][MAX_SUBDIV]) + margin)));
            end
        end
    endtask

    function automatic longint pick_coord(int d, int kind, longint off);
        longint lo, hi;
        int     n, c;
        n  = n_cells(GEN, d);
        lo = longint'(bnd_st[GEN][d][0]);
        hi = longint'(bnd_st[GEN][d][1]);
        case (kind)
            0: begin
                if (grid_mode == GRID_UNSORTED) return rnd_range(lo, hi);
                return rnd_range(longint'(bp_st[GEN][d][0]), longint'(bp_st[GEN][d][n]));
            end
            1: return longint'(bp_st[GEN][d][$urandom_range(0, n)]);
            2: begin
                c = $urandom_range(0, n - 1);
                return longint'(bp_st[GEN][d][c]) + off;
            end
            3: return rnd_range(lo, hi);
            default: begin
                if (lo > -64'sd2147483648 && ($urandom_range(0, 1) || hi >= 64'sd2147483647))
                    return rnd_range(-64'sd2147483648, lo - 1);
                if (hi < 64'sd2147483647) return rnd_range(hi + 1, 64'sd2147483647);
                return longint'($signed($urandom));
            end
        endcase
    endfunction

    task automatic random_point();
        int     r, kind0, kind1;
        longint off, w;
        r = $urandom_range(0, 99);
        if (r < 55)      kind0 = 0;
        else if (r < 68) kind0 = 1;
        else if (r < 80) kind0 = 2;
        else if (r < 88) kind0 = 3;
        else             kind0 = 4;
        kind1 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : kind0;
        w = longint'(bp_st[GEN][0][1]) - longint'(bp_st[GEN][0][0]);
        off = (w > 1) ? rnd_range(0, w - 1) : 0;
        add_point(pick_coord(0, kind0, off), pick_coord(1, kind1, off));
    endtask

    task automatic random_items(int cnt);
        int r;
        for (int i = 0; i < cnt; i++) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                random_point();
            end else if (r < 82) begin
                add_write(CMD_WR_W, $urandom_range(0, NF - 1), $urandom_range(0, NW_MAX - 1),
                          rand_weight());
            end else begin
                // mostly ignored writes; the in-range ones overwrite store entries
                add_write(t_cmd'($urandom_range(0, 2)), $urandom_range(0, 7),
                          $urandom_range(0, 1023), $urandom);
            end
        end
    endtask

    task automatic drain();
        while (pend_q.size() > 0 || in_valid || exp_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic directed_items();
        longint lo0, hi0, lo1, hi1, p0, p1;
        add_write(CMD_WR_BP, 7, 3, $urandom);
        add_write(CMD_WR_BP, 0, 1023, $urandom);
        add_write(CMD_WR_W, 2, 5, $urandom);
        add_write(CMD_WR_W, 7, 1023, $urandom);
        add_write(CMD_WR_BND, 1, 2, $urandom);
        add_write(CMD_WR_BND, 4, 0, $urandom);
        lo0 = longint'(bnd_st[GEN][0][0]);
        hi0 = longint'(bnd_st[GEN][0][1]);
        lo1 = longint'(bnd_st[GEN][1][0]);
        hi1 = longint'(bnd_st[GEN][1][1]);
        p0 = longint'(bp_st[GEN][0][n_cells(GEN, 0)]);
        p1 = longint'(bp_st[GEN][1][n_cells(GEN, 1)]);
        add_point(longint'(bp_st[GEN][0][0]), longint'(bp_st[GEN][1][0]));
        add_point(p0, p1);
        add_point(lo0, hi1);
        add_point(hi0, lo1);
        add_point(-64'sd2147483648, 64'sd2147483647);
        add_point(64'sd2147483647, -64'sd2147483648);
        add_point(lo0 - 1, lo1);
        add_point(lo0, hi1 + 1);
        add_point(p0 + 1, lo1);
        add_point((longint'(bp_st[GEN][0][0]) + p0) / 2, (longint'(bp_st[GEN][1][0]) + p1) / 2);
        add_point(longint'(bp_st[GEN][0][0]) + 1, longint'(bp_st[GEN][1][0]) + 1);
    endtask

    initial begin
        for (int v = 0; v < 2; v++)
            for (int r = 0; r < CFG_N; r++) subdiv[v][r] = 1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        set_config(1, 0, 0, 31);
        setup_grid(GRID_IRREGULAR);
        directed_items();
        random_items(30);
        drain();

        set_config(16, 16, 16, 16);
        setup_grid(GRID_UNIFORM);
        random_items(60);
        drain();

        set_config(17, 5, 31, 0);
        setup_grid(GRID_WIDE);
        random_items(50);
        drain();

        set_config(7, 12, 3, 9);
        setup_grid(GRID_UNSORTED);
        random_items(50);
        drain();

        set_config($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                   $urandom_range(0, 31));
        setup_grid(GRID_IRREGULAR);
        random_items(60);
        drain();

        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYC_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || o_in_ready) begin
            if (pend_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 9)) begin
                in_valid <= 1'b1;
                in_data  <= pend_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        out_ready <= i_rst_n && (quiet || $urandom_range(0, 99) >= 9);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (cfg_we) subdiv[MDL][cfg_addr] = cfg_data;
            if (in_valid && o_in_ready) begin
                if (in_data.cmd == CMD_EVAL) predict_point(in_data);
                else store_beat(MDL, in_data);
            end
            if (o_out_valid && out_ready) begin
                if (exp_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, o_out_data);
                    fails++;
                end else begin
                    want = exp_q.pop_front();
                    if (o_out_data.out_index !== want.out_index ||
                        o_out_data.out_value !== want.out_value ||
                        o_out_data.outside !== want.outside ||
                        o_out_data.last !== want.last) begin
                        $display("%0t: result mismatch, expected idx %0d val %h out %b last %b,",
                                 $time, want.out_index, want.out_value, want.outside, want.last);
                        $display("%0t:   actual idx %0d val %h out %b last %b", $time,
                                 o_out_data.out_index, o_out_data.out_value,
                                 o_out_data.outside, o_out_data.last);
                        fails++;
                    end
                end
            end
        end
    end

endmodule
